### sv/cim_pkg.sv
// shared types, codes and helper functions of the checked integer multiplier
`timescale 1ns / 1ps

package cim_pkg;

   // operand kind codes
   localparam logic [1:0] KIND_UNS  = 2'd0;
   localparam logic [1:0] KIND_SGN  = 2'd1;
   localparam logic [1:0] KIND_DEC  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // operand width codes
   localparam logic [1:0] WID_8  = 2'd0;
   localparam logic [1:0] WID_16 = 2'd1;
   localparam logic [1:0] WID_32 = 2'd2;
   localparam logic [1:0] WID_64 = 2'd3;

   // type codes of the request
   localparam logic [3:0] FUNC_U8   = 4'd0;
   localparam logic [3:0] FUNC_U64  = 4'd3;
   localparam logic [3:0] FUNC_I8   = 4'd4;
   localparam logic [3:0] FUNC_I64  = 4'd7;
   localparam logic [3:0] FUNC_DEC4 = 4'd8;
   localparam logic [3:0] FUNC_DEC9 = 4'd9;
   localparam logic [3:0] FUNC_DEC18 = 4'd10;

   // decimal bounds
   localparam logic [63:0] DEC4_BOUND  = 64'd9999;
   localparam logic [63:0] DEC9_BOUND  = 64'd999999999;
   localparam logic [63:0] DEC18_BOUND = 64'd999999999999999999;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] width;
      logic       sign_diff;
   } cim_tag_type;

   typedef struct packed {
      logic        valid;
      cim_tag_type tag;
   } cim_stage_type;

   function automatic logic [63:0] cim_mask(input logic [1:0] width);
      logic [63:0] m;
      case (width)
         WID_8:   m = 64'h0000_0000_0000_00ff;
         WID_16:  m = 64'h0000_0000_0000_ffff;
         WID_32:  m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic cim_sign_bit(input logic [63:0] v, input logic [1:0] width);
      logic s;
      case (width)
         WID_8:   s = v[7];
         WID_16:  s = v[15];
         WID_32:  s = v[31];
         default: s = v[63];
      endcase
      return s;
   endfunction

endpackage

### sv/cim_if.sv
// request and response channel interfaces of the checked integer multiplier
`timescale 1ns / 1ps

interface cim_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  func;
   logic [63:0] left_operand;
   logic [63:0] right_operand;

   modport source (output valid, output func, output left_operand, output right_operand,
                   input ready);
   modport sink (input valid, input func, input left_operand, input right_operand,
                 output ready);
endinterface

interface cim_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] product;
   logic        ok;

   modport source (output valid, output product, output ok, input ready);
   modport sink (input valid, input product, input ok, output ready);
endinterface

### sv/cim_decode.sv
// first pipeline stage: type decode, operand masking and magnitudes
`timescale 1ns / 1ps

module cim_decode
   import cim_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   cim_req_if.sink       req_chan,
   output cim_stage_type dec_stage,
   output logic [63:0]   dec_left_mag,
   output logic [63:0]   dec_right_mag,
   input  logic          dec_ready
);

   logic        valid_ff;
   cim_tag_type tag_ff, tag_in;
   logic [63:0] left_mag_ff, left_mag_in;
   logic [63:0] right_mag_ff, right_mag_in;
   logic        load;

   logic [63:0] mask;
   logic [63:0] left_val, right_val;
   logic        left_neg, right_neg;

   assign req_chan.ready = !valid_ff || dec_ready;
   assign load = req_chan.valid && req_chan.ready;

   always_comb begin
      tag_in.kind = KIND_NONE;
      tag_in.width = WID_64;
      case (req_chan.func) inside
         [FUNC_U8:FUNC_U64]: begin
            tag_in.kind = KIND_UNS;
            tag_in.width = req_chan.func[1:0];
         end
         [FUNC_I8:FUNC_I64]: begin
            tag_in.kind = KIND_SGN;
            tag_in.width = req_chan.func[1:0];
         end
         FUNC_DEC4: begin
            tag_in.kind = KIND_DEC;
            tag_in.width = WID_16;
         end
         FUNC_DEC9: begin
            tag_in.kind = KIND_DEC;
            tag_in.width = WID_32;
         end
         FUNC_DEC18: begin
            tag_in.kind = KIND_DEC;
            tag_in.width = WID_64;
         end
         default: begin
            tag_in.kind = KIND_NONE;
            tag_in.width = WID_64;
         end
      endcase

      mask = cim_mask(tag_in.width);
      left_val = req_chan.left_operand & mask;
      right_val = req_chan.right_operand & mask;
      left_neg = (tag_in.kind == KIND_SGN || tag_in.kind == KIND_DEC)
                 && cim_sign_bit(left_val, tag_in.width);
      right_neg = (tag_in.kind == KIND_SGN || tag_in.kind == KIND_DEC)
                  && cim_sign_bit(right_val, tag_in.width);
      left_mag_in = left_neg ? ((~left_val) & mask) + 64'd1 : left_val;
      right_mag_in = right_neg ? ((~right_val) & mask) + 64'd1 : right_val;
      tag_in.sign_diff = left_neg ^ right_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff <= tag_in;
         left_mag_ff <= left_mag_in;
         right_mag_ff <= right_mag_in;
      end
   end

   assign dec_stage.valid = valid_ff;
   assign dec_stage.tag = tag_ff;
   assign dec_left_mag = left_mag_ff;
   assign dec_right_mag = right_mag_ff;

endmodule

### sv/cim_mul.sv
// second and third pipeline stages: 32x32 partial products, then their sum
`timescale 1ns / 1ps

module cim_mul
   import cim_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cim_stage_type dec_stage,
   input  logic [63:0]   dec_left_mag,
   input  logic [63:0]   dec_right_mag,
   output logic          dec_ready,
   output cim_stage_type sum_stage,
   output logic [63:0]   sum_low,
   output logic          sum_high_zero,
   input  logic          sum_ready
);

   // partial product stage
   logic        pp_valid_ff;
   cim_tag_type pp_tag_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic        pp_ready;

   // sum stage
   logic        sm_valid_ff;
   cim_tag_type sm_tag_ff;
   logic [63:0] low_ff, low_in;
   logic        high_zero_ff, high_zero_in;

   logic [33:0] mid;
   logic [63:0] high;

   assign dec_ready = !pp_valid_ff || pp_ready;
   assign pp_ready = !sm_valid_ff || sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
         sm_valid_ff <= 1'b0;
      end else begin
         if (dec_ready) begin
            pp_valid_ff <= dec_stage.valid;
         end
         if (pp_ready) begin
            sm_valid_ff <= pp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dec_stage.valid && dec_ready) begin
         pp_tag_ff <= dec_stage.tag;
         p00_ff <= dec_left_mag[31:0] * dec_right_mag[31:0];
         p01_ff <= dec_left_mag[31:0] * dec_right_mag[63:32];
         p10_ff <= dec_left_mag[63:32] * dec_right_mag[31:0];
         p11_ff <= dec_left_mag[63:32] * dec_right_mag[63:32];
      end
   end

   always_comb begin
      mid = {2'b00, p00_ff[63:32]} + {2'b00, p01_ff[31:0]} + {2'b00, p10_ff[31:0]};
      low_in = {mid[31:0], p00_ff[31:0]};
      high = p11_ff + {32'd0, p01_ff[63:32]} + {32'd0, p10_ff[63:32]}
             + {62'd0, mid[33:32]};
      high_zero_in = (high == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (pp_valid_ff && pp_ready) begin
         sm_tag_ff <= pp_tag_ff;
         low_ff <= low_in;
         high_zero_ff <= high_zero_in;
      end
   end

   assign sum_stage.valid = sm_valid_ff;
   assign sum_stage.tag = sm_tag_ff;
   assign sum_low = low_ff;
   assign sum_high_zero = high_zero_ff;

endmodule

### sv/cim_check.sv
// last pipeline stage: range check, sign restore and response register
`timescale 1ns / 1ps

module cim_check
   import cim_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cim_stage_type sum_stage,
   input  logic [63:0]   sum_low,
   input  logic          sum_high_zero,
   output logic          sum_ready,
   cim_rsp_if.source     rsp_chan
);

   logic        valid_ff;
   cim_tag_type tag_ff;
   logic [63:0] product_ff, product_in;
   logic        ok_ff, ok_in;

   logic [63:0] mask;
   logic [63:0] limit;
   logic        neg;

   assign sum_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      mask = cim_mask(sum_stage.tag.width);
      neg = sum_stage.tag.sign_diff && (sum_low != 64'd0);
      case (sum_stage.tag.width)
         WID_8:   limit = neg ? 64'd128 : 64'd127;
         WID_16:  limit = neg ? 64'd32768 : 64'd32767;
         WID_32:  limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
         default: limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      endcase
      if (sum_stage.tag.kind == KIND_DEC) begin
         case (sum_stage.tag.width)
            WID_16:  limit = DEC4_BOUND;
            WID_32:  limit = DEC9_BOUND;
            default: limit = DEC18_BOUND;
         endcase
      end

      case (sum_stage.tag.kind)
         KIND_UNS: ok_in = sum_high_zero && ((sum_low & ~mask) == 64'd0);
         KIND_SGN, KIND_DEC: ok_in = sum_high_zero && (sum_low <= limit);
         default: ok_in = 1'b0;
      endcase

      product_in = ok_in ? ((neg ? (64'd0 - sum_low) : sum_low) & mask) : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sum_ready) begin
         valid_ff <= sum_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_stage.valid && sum_ready) begin
         tag_ff <= sum_stage.tag;
         product_ff <= product_in;
         ok_ff <= ok_in;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.product = product_ff;
   assign rsp_chan.ok = ok_ff;

   // failed checks give a zero product
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !ok_ff |-> product_ff == 64'd0)
      else $error("failed multiply with nonzero product");

   // a good 8-bit result stays inside its width
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && ok_ff && tag_ff.width == WID_8 |-> product_ff[63:8] == 56'd0)
      else $error("8-bit product spills above its width");

   // unused type codes never pass
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && tag_ff.kind == KIND_NONE |-> !ok_ff)
      else $error("unused type code reported ok");

   // an unsigned type never carries a sign difference
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && tag_ff.kind == KIND_UNS |-> !tag_ff.sign_diff)
      else $error("unsigned result tagged with sign");

endmodule

### sv/checked_integer_multiply.sv
// Overflow-checked integer multiply: each request gives a type code and two 64-bit operands
// and returns the exact product at that type's width with an ok flag (clear, and product
// zero, on overflow, decimal bound breach or an unused type code). The block is a
// four-stage pipeline: decode and operand magnitude, four 32x32 partial products, the
// 128-bit sum of those products, then the range check and sign restore into the response
// register. A request is taken every cycle unless the response side stalls; it passes
// through the decode, partial product, sum and response registers in turn. Back-pressure
// on the response side stalls all stages in place, each empty stage still taking a request.
`timescale 1ns / 1ps

module checked_integer_multiply
   import cim_pkg::*;
(
   input logic       clock,
   input logic       reset,
   cim_req_if.sink   req_chan,
   cim_rsp_if.source rsp_chan
);

   cim_stage_type dec_stage;
   logic [63:0]   dec_left_mag, dec_right_mag;
   logic          dec_ready;
   cim_stage_type sum_stage;
   logic [63:0]   sum_low;
   logic          sum_high_zero;
   logic          sum_ready;

   cim_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .dec_stage     (dec_stage),
      .dec_left_mag  (dec_left_mag),
      .dec_right_mag (dec_right_mag),
      .dec_ready     (dec_ready)
   );

   cim_mul u_mul (
      .clock         (clock),
      .reset         (reset),
      .dec_stage     (dec_stage),
      .dec_left_mag  (dec_left_mag),
      .dec_right_mag (dec_right_mag),
      .dec_ready     (dec_ready),
      .sum_stage     (sum_stage),
      .sum_low       (sum_low),
      .sum_high_zero (sum_high_zero),
      .sum_ready     (sum_ready)
   );

   cim_check u_check (
      .clock         (clock),
      .reset         (reset),
      .sum_stage     (sum_stage),
      .sum_low       (sum_low),
      .sum_high_zero (sum_high_zero),
      .sum_ready     (sum_ready),
      .rsp_chan      (rsp_chan)
   );

endmodule
